/* rtl/rgb_median_filter_3x3_top_assert.svh */
// Assertion macros for the 3x3 RGB median filter checker.
`ifndef RGB_MEDIAN_FILTER_3X3_TOP_ASSERT_SVH
`define RGB_MEDIAN_FILTER_3X3_TOP_ASSERT_SVH

// Clocked check, muted while reset is held.
`define RMF_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define RMF_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/rmf_pkg.sv */
// Package for the 3x3 RGB median filter: types, sizes and sort helpers.
package rmf_pkg;

    localparam int SAMPLE_W = 8;
    localparam int ROW_TAPS = 3;
    localparam int WIN_TAPS = ROW_TAPS * ROW_TAPS;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef t_sample [WIN_TAPS-1:0] t_window;
    typedef t_sample [ROW_TAPS-1:0] t_triple;

    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
    } t_pipe_ctl;

    function automatic t_sample min2(input t_sample a, input t_sample b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_sample max2(input t_sample a, input t_sample b);
        return (a < b) ? b : a;
    endfunction

    function automatic t_sample min3(input t_triple t);
        return min2(min2(t[0], t[1]), t[2]);
    endfunction

    function automatic t_sample max3(input t_triple t);
        return max2(max2(t[0], t[1]), t[2]);
    endfunction

    function automatic t_sample med3(input t_triple t);
        return max2(min2(t[0], t[1]), min2(max2(t[0], t[1]), t[2]));
    endfunction

    // ascending: [0] low, [1] mid, [2] high
    function automatic t_triple sort3(input t_triple t);
        t_triple s;
        s[0] = min3(t);
        s[1] = med3(t);
        s[2] = max3(t);
        return s;
    endfunction

endpackage

/* rtl/rgb_median_filter_3x3_top.sv */
// Top level of the 3x3 RGB median filter.
//
//  channel   handshake              payload
//  --------  ---------------------  ------------------------------------------
//  window    i_valid  / o_ready     i_pix_* : nine 24-bit BGR pixels
//  result    o_valid  / i_ready     o_median_red / _green / _blue, 8 bits each
//
// An accepted window moves through the row sort, column select and median of
// three registers in turn; o_valid rises when it reaches the last, and the
// result can leave from there. One window per clock is sustained with
// i_ready high. The three register stages each advance when empty or when
// the next stage advances, so bubbles close up; o_ready drops only when all
// three stages hold items and i_ready is low.
// Reset (synchronous, active low) clears the valid bits only; data
// registers load freely.
// A stall holds each full stage that cannot pass its item on; nothing is dropped or repeated.
module rgb_median_filter_3x3_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // window channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [23:0] i_pix_top_left,
    input  logic [23:0] i_pix_top_mid,
    input  logic [23:0] i_pix_top_right,
    input  logic [23:0] i_pix_mid_left,
    input  logic [23:0] i_pix_center,
    input  logic [23:0] i_pix_mid_right,
    input  logic [23:0] i_pix_bot_left,
    input  logic [23:0] i_pix_bot_mid,
    input  logic [23:0] i_pix_bot_right,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_median_red,
    output logic [7:0]  o_median_green,
    output logic [7:0]  o_median_blue
);
    import rmf_pkg::*;

    t_pipe_ctl  ctl;
    logic [23:0] pix [WIN_TAPS];
    t_window    win_red, win_green, win_blue;

    // raster order, row 0 first
    assign pix[0] = i_pix_top_left;
    assign pix[1] = i_pix_top_mid;
    assign pix[2] = i_pix_top_right;
    assign pix[3] = i_pix_mid_left;
    assign pix[4] = i_pix_center;
    assign pix[5] = i_pix_mid_right;
    assign pix[6] = i_pix_bot_left;
    assign pix[7] = i_pix_bot_mid;
    assign pix[8] = i_pix_bot_right;

    // split packed BGR: blue 7:0, green 15:8, red 23:16
    always_comb begin
        for (int k = 0; k < WIN_TAPS; k++) begin
            win_blue[k]  = pix[k][7:0];
            win_green[k] = pix[k][15:8];
            win_red[k]   = pix[k][23:16];
        end
    end

    rmf_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_ready (i_ready),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_ctl       (ctl)
    );

    // channels never mix: one independent datapath each
    rmf_chan_pipe u_red (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_win    (win_red),
        .o_median (o_median_red)
    );

    rmf_chan_pipe u_green (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_win    (win_green),
        .o_median (o_median_green)
    );

    rmf_chan_pipe u_blue (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_win    (win_blue),
        .o_median (o_median_blue)
    );

endmodule

/* rtl/rmf_pipe_ctrl.sv */
// Valid bits and per-stage enables for the three-stage median pipeline.
module rmf_pipe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output rmf_pkg::t_pipe_ctl o_ctl
);
    import rmf_pkg::*;

    logic r_v1, r_v2, r_v3;
    logic n_v1, n_v2, n_v3;
    t_pipe_ctl ctl;

    // a stage advances when it is empty or the one after it advances
    always_comb begin
        ctl.s3_en = !r_v3 || i_out_ready;
        ctl.s2_en = !r_v2 || ctl.s3_en;
        ctl.s1_en = !r_v1 || ctl.s2_en;
        n_v1 = ctl.s1_en ? i_in_valid : r_v1;
        n_v2 = ctl.s2_en ? r_v1 : r_v2;
        n_v3 = ctl.s3_en ? r_v2 : r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    assign o_ctl       = ctl;
    assign o_in_ready  = ctl.s1_en;
    assign o_out_valid = r_v3;

endmodule

/* rtl/rmf_chan_pipe.sv */
// One color channel: row sort, column select, final median of three.
module rmf_chan_pipe (
    input  logic               i_clk,
    input  rmf_pkg::t_pipe_ctl i_ctl,
    input  rmf_pkg::t_window   i_win,
    output rmf_pkg::t_sample   o_median
);
    import rmf_pkg::*;

    t_triple r_lo, r_mid, r_hi;   // stage 1: sorted rows, split by rank
    t_triple n_lo, n_mid, n_hi;
    t_triple r_cand;              // stage 2: max of lows, med of mids, min of highs
    t_triple n_cand;
    t_sample r_med;               // stage 3: result
    t_sample n_med;

    always_comb begin
        t_triple row;
        t_triple srt;
        for (int r = 0; r < ROW_TAPS; r++) begin
            for (int c = 0; c < ROW_TAPS; c++) begin
                row[c] = i_win[r*ROW_TAPS + c];
            end
            srt = sort3(row);
            n_lo[r]  = srt[0];
            n_mid[r] = srt[1];
            n_hi[r]  = srt[2];
        end
        n_cand[0] = max3(r_lo);
        n_cand[1] = med3(r_mid);
        n_cand[2] = min3(r_hi);
        n_med     = med3(r_cand);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_en) begin
            r_lo  <= n_lo;
            r_mid <= n_mid;
            r_hi  <= n_hi;
        end
        if (i_ctl.s2_en) begin
            r_cand <= n_cand;
        end
        if (i_ctl.s3_en) begin
            r_med <= n_med;
        end
    end

    assign o_median = r_med;

endmodule

/* rtl/rmf_checker.sv */
// Port-level checks for the 3x3 RGB median filter, bound to the top level.
`include "rgb_median_filter_3x3_top_assert.svh"

module rmf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_median_red,
    input logic [7:0] o_median_green,
    input logic [7:0] o_median_blue
);

    // a stalled result keeps its valid
    `RMF_ASSERT_CLK(a_out_hold, o_valid && !i_ready |=> o_valid, "result valid dropped in stall")

    // a stalled result keeps its value
    `RMF_ASSERT_CLK(a_out_stable, o_valid && !i_ready |=> $stable(o_median_red) && $stable(o_median_green) && $stable(o_median_blue), "result changed in stall")

    // no result shows in the cycle after a reset edge
    `RMF_ASSERT_ALL(a_rst_clear, !i_rst_n |=> !o_valid, "result valid after reset")

    // a free output side never stalls the input side
    `RMF_ASSERT_CLK(a_ready_flow, i_ready |-> o_ready, "input stalled with output ready")

endmodule

bind rgb_median_filter_3x3_top rmf_checker u_rmf_checker (.*);
